FILE: sv/fgpo_pkg.sv
// Film grain pixel overlay: shared types and constants.
// Used by the channel interfaces and the top level.
package fgpo_pkg;

    typedef enum logic [1:0] {
        OP_PIXEL       = 2'd0,
        OP_TMPL_WR     = 2'd1,
        OP_SCALE_WR    = 2'd2,
        OP_FRAME_START = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_FRAME_SEED   = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GEN1,
        ST_GEN2,
        ST_WAIT,
        ST_COLOFF,
        ST_ROWOFF,
        ST_ADDR,
        ST_AMOD1,
        ST_AMOD2,
        ST_READ,
        ST_MULT,
        ST_OUT
    } state_t;

    localparam int TEMPLATE_SIDE_DEF = 64;
    localparam int OFFSET_RANGE_DEF  = 56;
    localparam int MAX_LINE_DEF      = 4096;

    localparam int CFG_DW   = 32;
    localparam int DIM_W    = 13;
    localparam int IDX_W    = 12;
    localparam int PIX_W    = 8;
    localparam int SCALE_BINS = 32;
    localparam int SCALE_AW   = 5;

    localparam logic [DIM_W-1:0]  WIDTH_RESET  = 13'd64;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = 13'd64;
    localparam logic [CFG_DW-1:0] SEED_RESET   = 32'd0;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;

    localparam logic [PIX_W-1:0] GRAIN_BIAS = 8'd128;
    localparam logic [PIX_W-1:0] PIXEL_MAX  = 8'd255;

endpackage

FILE: sv/fgpo_in_if.sv
// Input channel of the film grain overlay: valid/ready plus item payload.
// Depends on fgpo_pkg for the opcode type.
interface fgpo_in_if import fgpo_pkg::*; ();
    logic                 valid;
    logic                 ready;
    opcode_t              opcode;
    logic [IDX_W-1:0]     table_index;
    logic [PIX_W-1:0]     data_value;

    modport source (output valid, output opcode, output table_index, output data_value,
                    input ready);
    modport sink   (input valid, input opcode, input table_index, input data_value,
                    output ready);
endinterface

FILE: sv/fgpo_out_if.sv
// Output channel of the film grain overlay: valid/ready plus result payload.
// Depends on fgpo_pkg for the pixel width.
interface fgpo_out_if import fgpo_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     pixel_out;
    logic                 last_in_frame;

    modport source (output valid, output pixel_out, output last_in_frame, input ready);
    modport sink   (input valid, input pixel_out, input last_in_frame, output ready);
endinterface

FILE: sv/fgpo_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fgpo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fgpo_cmod.sv
// Two-stage remainder by a constant: reciprocal multiply, then one
// compare-and-subtract correction. No dependencies.
module fgpo_cmod #(
    parameter int W   = 16,
    parameter int DIV = 56
) (
    input  logic                   clk,
    input  logic [W-1:0]           v_in,
    output logic [$clog2(DIV)-1:0] r_out
);

    localparam int RW = $clog2(DIV);
    localparam int XW = (W > RW + 1) ? W : RW + 1;
    localparam longint unsigned RECIP = (64'd1 << W) / DIV;
    localparam logic [W-1:0] RECIP_W = W'(RECIP);

    logic [2*W-1:0] prod;
    logic [W-1:0]   q_reg;
    logic [W-1:0]   v_reg;
    logic [XW-1:0]  qd;
    logic [XW-1:0]  diff;
    logic [XW-1:0]  rem;
    logic [RW-1:0]  r_reg;

    // estimate is floor or floor-1, so one correction suffices
    assign prod = {{W{1'b0}}, v_in} * {{W{1'b0}}, RECIP_W};
    assign qd   = XW'(q_reg) * XW'(DIV);
    assign diff = XW'(v_reg) - qd;
    assign rem  = (diff >= XW'(DIV)) ? diff - XW'(DIV) : diff;

    always_ff @(posedge clk)
    begin
        q_reg <= prod[2*W-1:W];
        v_reg <= v_in;
        r_reg <= RW'(rem);
    end

    assign r_out = r_reg;

endmodule

FILE: sv/film_grain_pixel_overlay.sv
// Film grain pixel overlay top level: sequencer, raster counters, generator.
// Depends on fgpo_pkg, fgpo_in_if, fgpo_out_if, fgpo_ram and fgpo_cmod.
//
//   port      | kind       | payload
//   ----------+------------+-------------------------------------------
//   items     | valid/rdy  | opcode, table_index, data_value
//   results   | valid/rdy  | pixel_out, last_in_frame
//   cfg_*     | write only | cfg_index, cfg_data (frame_width/height/seed)
//
// Table writes and frame starts are done in the idle state. A pixel runs
// two generator steps, the offset and address remainder units, the
// template memory read and the grain multiply one after the other.
// Reset clears control state and loads register defaults; memories hold
// garbage until written. A result waits in the output register; the next
// item is taken meanwhile, and a pixel holds in its final step until the
// output register is free.
module film_grain_pixel_overlay import fgpo_pkg::*; #(
    parameter int TEMPLATE_SIDE = TEMPLATE_SIDE_DEF,
    parameter int OFFSET_RANGE  = OFFSET_RANGE_DEF,
    parameter int MAX_LINE      = MAX_LINE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    fgpo_in_if.sink           items,
    fgpo_out_if.source        results
);

    localparam int TMPL_SIZE = TEMPLATE_SIDE * TEMPLATE_SIDE;
    localparam int TMPL_AW   = $clog2(TMPL_SIZE);
    localparam int OW        = $clog2(OFFSET_RANGE);
    localparam int FULL_MAX  = (OFFSET_RANGE - 1) * TEMPLATE_SIDE + OFFSET_RANGE - 1;
    localparam int FW        = $clog2(FULL_MAX + 1);
    localparam int CW        = $clog2(MAX_LINE);
    localparam int DW        = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;

    localparam logic [OW-1:0] BLK_LAST = OW'(OFFSET_RANGE - 1);
    localparam logic [OW:0]   RANGE_X  = (OW + 1)'(OFFSET_RANGE);
    localparam logic [DW-1:0] MAX_DIM  = DW'(MAX_LINE);

    // configuration
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [CFG_DW-1:0] seed_reg;

    // control state
    state_t         state_reg, state_next;
    logic [31:0]    rnd_reg;
    logic [CW-1:0]  col_reg;
    logic [CW-1:0]  row_reg;
    logic [OW-1:0]  col_blk_reg;
    logic [OW-1:0]  row_blk_reg;
    logic           out_valid_reg;

    // payload
    logic [PIX_W-1:0]   luma_reg;
    logic [OW-1:0]      rx_reg;
    logic [OW-1:0]      ry_reg;
    logic [FW-1:0]      addr_full_reg;
    logic signed [16:0] prod_reg;
    logic [PIX_W-1:0]   pix_out_reg;
    logic               last_out_reg;

    logic                 accept;
    logic                 out_load;
    logic                 tmpl_we, tmpl_re, scale_we, scale_re;
    logic [TMPL_AW-1:0]   tmpl_addr;
    logic [PIX_W-1:0]     tmpl_rdata;
    logic [PIX_W-1:0]     scale_rdata;
    logic [OW-1:0]        offset;
    logic [OW:0]          off_sum;
    logic [OW-1:0]        off_wrap;
    logic [OW-1:0]        blk_sel;
    logic [31:0]          rnd_step;

    logic [DW-1:0]        w_raw, h_raw, w_eff, h_eff;
    logic                 line_end, frame_end;

    logic signed [7:0]    grain;
    logic signed [16:0]   biased;
    logic signed [10:0]   scaled;
    logic signed [11:0]   sum;
    logic [PIX_W-1:0]     pix_clamped;

    assign accept   = items.valid && items.ready;
    assign rnd_step = rnd_reg * LCG_MUL + LCG_ADD;

    // memories
    fgpo_ram #(.WIDTH(PIX_W), .DEPTH(TMPL_SIZE)) u_tmpl_ram (
        .clk   (clk),
        .we    (tmpl_we),
        .waddr (TMPL_AW'(items.table_index)),
        .wdata (items.data_value),
        .re    (tmpl_re),
        .raddr (tmpl_addr),
        .rdata (tmpl_rdata)
    );

    fgpo_ram #(.WIDTH(PIX_W), .DEPTH(SCALE_BINS)) u_scale_ram (
        .clk   (clk),
        .we    (scale_we),
        .waddr (items.table_index[SCALE_AW-1:0]),
        .wdata (items.data_value),
        .re    (scale_re),
        .raddr (items.data_value[PIX_W-1:PIX_W-SCALE_AW]),
        .rdata (scale_rdata)
    );

    // remainder units
    fgpo_cmod #(.W(16), .DIV(OFFSET_RANGE)) u_off_mod (
        .clk   (clk),
        .v_in  (rnd_reg[31:16]),
        .r_out (offset)
    );

    fgpo_cmod #(.W(FW), .DIV(TMPL_SIZE)) u_addr_mod (
        .clk   (clk),
        .v_in  (addr_full_reg),
        .r_out (tmpl_addr)
    );

    // block offset plus random offset, both below the range
    assign blk_sel  = (state_reg == ST_COLOFF) ? col_blk_reg : row_blk_reg;
    assign off_sum  = {1'b0, blk_sel} + {1'b0, offset};
    assign off_wrap = (off_sum >= RANGE_X) ? OW'(off_sum - RANGE_X) : OW'(off_sum);

    // dimensions
    assign w_raw = DW'(width_reg);
    assign h_raw = DW'(height_reg);
    assign w_eff = (w_raw == '0) ? DW'(1) : ((w_raw > MAX_DIM) ? MAX_DIM : w_raw);
    assign h_eff = (h_raw == '0) ? DW'(1) : ((h_raw > MAX_DIM) ? MAX_DIM : h_raw);
    assign line_end  = (DW'(col_reg) + DW'(1)) >= w_eff;
    assign frame_end = (DW'(row_reg) + DW'(1)) >= h_eff;

    // grain scaling: (t-128) is t with the top bit flipped
    assign grain  = signed'(tmpl_rdata ^ GRAIN_BIAS);
    assign biased = prod_reg + (prod_reg[16] ? 17'sd63 : 17'sd0);
    assign scaled = biased[16:6];
    assign sum    = signed'({4'b0000, luma_reg}) + {scaled[10], scaled};
    assign pix_clamped = sum[11] ? '0 : ((sum > 12'sd255) ? PIXEL_MAX : sum[7:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept && items.opcode == OP_PIXEL) state_next = ST_GEN1;
            ST_GEN1:   state_next = ST_GEN2;
            ST_GEN2:   state_next = ST_WAIT;
            ST_WAIT:   state_next = ST_COLOFF;
            ST_COLOFF: state_next = ST_ROWOFF;
            ST_ROWOFF: state_next = ST_ADDR;
            ST_ADDR:   state_next = ST_AMOD1;
            ST_AMOD1:  state_next = ST_AMOD2;
            ST_AMOD2:  state_next = ST_READ;
            ST_READ:   state_next = ST_MULT;
            ST_MULT:   state_next = ST_OUT;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        items.ready = 1'b0;
        tmpl_we     = 1'b0;
        scale_we    = 1'b0;
        scale_re    = 1'b0;
        tmpl_re     = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                items.ready = 1'b1;
                tmpl_we  = accept && items.opcode == OP_TMPL_WR &&
                           int'(items.table_index) < TMPL_SIZE;
                scale_we = accept && items.opcode == OP_SCALE_WR &&
                           items.table_index < IDX_W'(SCALE_BINS);
                scale_re = accept && items.opcode == OP_PIXEL;
            end
            ST_READ: tmpl_re  = 1'b1;
            ST_OUT:  out_load = !out_valid_reg || results.ready;
            default:
            begin
                items.ready = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            seed_reg   <= SEED_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_FRAME_SEED:   seed_reg   <= cfg_data;
                default:          seed_reg   <= seed_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            col_blk_reg   <= '0;
            row_blk_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept && items.opcode == OP_FRAME_START)
            begin
                rnd_reg     <= seed_reg;
                col_reg     <= '0;
                row_reg     <= '0;
                col_blk_reg <= '0;
                row_blk_reg <= '0;
            end
            else if (state_reg == ST_GEN1 || state_reg == ST_GEN2)
            begin
                rnd_reg <= rnd_step;
            end
            else if (out_load)
            begin
                if (line_end)
                begin
                    col_reg     <= '0;
                    col_blk_reg <= '0;
                    if (frame_end)
                    begin
                        row_reg     <= '0;
                        row_blk_reg <= '0;
                    end
                    else
                    begin
                        row_reg <= row_reg + CW'(1);
                        if (row_reg[2:0] == 3'b111)
                        begin
                            row_blk_reg <= (row_blk_reg == BLK_LAST) ? '0
                                                                     : row_blk_reg + OW'(1);
                        end
                    end
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                    if (col_reg[2:0] == 3'b111)
                    begin
                        col_blk_reg <= (col_blk_reg == BLK_LAST) ? '0 : col_blk_reg + OW'(1);
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            luma_reg <= items.data_value;
        end
        if (state_reg == ST_COLOFF)
        begin
            rx_reg <= off_wrap;
        end
        if (state_reg == ST_ROWOFF)
        begin
            ry_reg <= off_wrap;
        end
        if (state_reg == ST_ADDR)
        begin
            addr_full_reg <= FW'(ry_reg) * FW'(TEMPLATE_SIDE) + FW'(rx_reg);
        end
        if (state_reg == ST_MULT)
        begin
            prod_reg <= grain * signed'({1'b0, scale_rdata});
        end
        if (out_load)
        begin
            pix_out_reg  <= pix_clamped;
            last_out_reg <= line_end && frame_end;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.pixel_out     = pix_out_reg;
    assign results.last_in_frame = last_out_reg;

    // checks
    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && items.opcode == OP_PIXEL |=> !items.ready)
        else $error("item taken while a pixel is in progress");

    a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the final step");

    a_blk_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_blk_reg <= BLK_LAST && row_blk_reg <= BLK_LAST)
        else $error("block offset out of range");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && line_end && frame_end |=> col_reg == '0 && row_reg == '0)
        else $error("raster counters not wrapped after last pixel");

endmodule
